### rtl/motion_direction_histogram_defines.svh
// Assertion macros for the motion direction histogram.
// Used by motion_direction_histogram.sv; expects clk and rst_n in scope.
`ifndef MOTION_DIRECTION_HISTOGRAM_DEFINES_SVH
`define MOTION_DIRECTION_HISTOGRAM_DEFINES_SVH

// expr must never be true
`define MDH_ASSERT_NEVER(lbl, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
        else $error(msg);

// ante implies cons in the same cycle
`define MDH_ASSERT_IMPLY(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// ante implies cons in the next cycle
`define MDH_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/mdh_pkg.sv
// Shared types, constants and tables for the motion direction histogram.
// No dependencies; imported by motion_direction_histogram.sv.
package mdh_pkg;

    localparam int COORD_BITS   = 16;
    localparam int NUM_BINS     = 36;
    localparam int BIN_W        = 6;
    localparam int CNT_W        = 10;
    localparam int ANG_W        = 9;
    localparam int DEG_W        = 7;
    localparam int TAN_W        = 22;
    localparam int TAN_FRAC     = 16;
    localparam int PROD_W       = TAN_W + COORD_BITS;
    localparam int SEARCH_STEPS = 7;

    localparam logic [CNT_W-1:0] COUNT_CEIL = 10'd1023;
    localparam logic [DEG_W-1:0] MAX_DEG    = 7'd89;
    localparam logic [BIN_W-1:0] LAST_BIN   = 6'(NUM_BINS - 1);

    localparam logic [ANG_W-1:0] ANG_90  = 9'd90;
    localparam logic [ANG_W-1:0] ANG_180 = 9'd180;
    localparam logic [ANG_W-1:0] ANG_270 = 9'd270;
    localparam logic [ANG_W-1:0] ANG_360 = 9'd360;

    // angle / 10 as (angle * 205) >> 11, exact for angles below 360
    localparam int BIN_RECIP = 205;
    localparam int BIN_SHIFT = 11;
    localparam int BIN_PROD_W = 17;

    localparam logic KIND_ANGLE = 1'b0;
    localparam logic KIND_COUNT = 1'b1;

    typedef struct packed {
        logic [COORD_BITS-1:0] prev_x;
        logic [COORD_BITS-1:0] prev_y;
        logic [COORD_BITS-1:0] cur_x;
        logic [COORD_BITS-1:0] cur_y;
        logic                  end_of_frame;
    } in_item_t;

    typedef struct packed {
        logic             kind;
        logic [ANG_W-1:0] angle_deg;
        logic [BIN_W-1:0] bin_index;
        logic [CNT_W-1:0] bin_count;
        logic             last;
    } out_item_t;

    // one item in the tangent search pipeline
    typedef struct packed {
        logic [COORD_BITS-1:0] adx;
        logic [COORD_BITS-1:0] ady;
        logic                  xneg;
        logic                  yneg;
        logic                  xzero;
        logic                  ygt;
        logic                  eof;
        logic [DEG_W-1:0]      lo;
    } srch_t;

    // resolved angle and bin
    typedef struct packed {
        logic [ANG_W-1:0] angle;
        logic [BIN_W-1:0] bin;
        logic             eof;
    } ang_item_t;

    // tan(d degrees) in unsigned Q16, rounded
    function automatic logic [TAN_W-1:0] tan_q16(input logic [DEG_W-1:0] d);
        logic [TAN_W-1:0] t;
        unique case (d)
            7'd0: t = 22'd0;             7'd1: t = 22'd1144;
            7'd2: t = 22'd2289;          7'd3: t = 22'd3435;
            7'd4: t = 22'd4583;          7'd5: t = 22'd5734;
            7'd6: t = 22'd6888;          7'd7: t = 22'd8047;
            7'd8: t = 22'd9210;          7'd9: t = 22'd10380;
            7'd10: t = 22'd11556;        7'd11: t = 22'd12739;
            7'd12: t = 22'd13930;        7'd13: t = 22'd15130;
            7'd14: t = 22'd16340;        7'd15: t = 22'd17560;
            7'd16: t = 22'd18792;        7'd17: t = 22'd20036;
            7'd18: t = 22'd21294;        7'd19: t = 22'd22566;
            7'd20: t = 22'd23853;        7'd21: t = 22'd25157;
            7'd22: t = 22'd26478;        7'd23: t = 22'd27818;
            7'd24: t = 22'd29179;        7'd25: t = 22'd30560;
            7'd26: t = 22'd31964;        7'd27: t = 22'd33392;
            7'd28: t = 22'd34846;        7'd29: t = 22'd36327;
            7'd30: t = 22'd37837;        7'd31: t = 22'd39378;
            7'd32: t = 22'd40951;        7'd33: t = 22'd42560;
            7'd34: t = 22'd44205;        7'd35: t = 22'd45889;
            7'd36: t = 22'd47615;        7'd37: t = 22'd49385;
            7'd38: t = 22'd51202;        7'd39: t = 22'd53070;
            7'd40: t = 22'd54991;        7'd41: t = 22'd56970;
            7'd42: t = 22'd59009;        7'd43: t = 22'd61113;
            7'd44: t = 22'd63287;        7'd45: t = 22'd65536;
            7'd46: t = 22'd67865;        7'd47: t = 22'd70279;
            7'd48: t = 22'd72785;        7'd49: t = 22'd75391;
            7'd50: t = 22'd78103;        7'd51: t = 22'd80930;
            7'd52: t = 22'd83882;        7'd53: t = 22'd86969;
            7'd54: t = 22'd90203;        7'd55: t = 22'd93595;
            7'd56: t = 22'd97161;        7'd57: t = 22'd100917;
            7'd58: t = 22'd104880;       7'd59: t = 22'd109070;
            7'd60: t = 22'd113512;       7'd61: t = 22'd118230;
            7'd62: t = 22'd123255;       7'd63: t = 22'd128622;
            7'd64: t = 22'd134369;       7'd65: t = 22'd140542;
            7'd66: t = 22'd147196;       7'd67: t = 22'd154393;
            7'd68: t = 22'd162207;       7'd69: t = 22'd170727;
            7'd70: t = 22'd180059;       7'd71: t = 22'd190330;
            7'd72: t = 22'd201699;       7'd73: t = 22'd214359;
            7'd74: t = 22'd228551;       7'd75: t = 22'd244584;
            7'd76: t = 22'd262851;       7'd77: t = 22'd283868;
            7'd78: t = 22'd308323;       7'd79: t = 22'd337153;
            7'd80: t = 22'd371673;       7'd81: t = 22'd413778;
            7'd82: t = 22'd466313;       7'd83: t = 22'd533748;
            7'd84: t = 22'd623533;       7'd85: t = 22'd749080;
            7'd86: t = 22'd937208;       7'd87: t = 22'd1250501;
            7'd88: t = 22'd1876706;      7'd89: t = 22'd3754555;
            default: t = '0;
        endcase
        return t;
    endfunction

    function automatic logic [BIN_W-1:0] ang_to_bin(input logic [ANG_W-1:0] ang);
        logic [BIN_PROD_W-1:0] p;
        p = BIN_PROD_W'(ang) * BIN_PROD_W'(BIN_RECIP);
        return p[BIN_SHIFT +: BIN_W];
    endfunction

endpackage

### rtl/motion_direction_histogram.sv
// Motion direction histogram: each input item is one tracked point (start and
// end position); the block reports its direction in whole degrees (0..359)
// and the 10-degree bin it falls in, and counts it into a 36-entry store of
// saturating 10-bit counts. An item flagged end_of_frame produces its angle
// report followed by all 36 bin counts (bin 0 first, last set on bin 35),
// and the store is then empty for the next frame. Items are accepted one per
// cycle while nothing stalls (output back-pressure or a frame-end dump); each
// item passes through the input stage, which loads at the accepting edge,
// seven binary-search steps over the tangent table (one multiply each),
// angle finalize, count read-modify-write and the output register. A
// frame-end dump occupies the single read port of the count memory while
// it reads all 36 bins; until the dump has drained, the counter takes no
// new item, and new items fill the search pipeline but do not reach the
// counter.
// After reset the store reads as zero at once through per-bin valid flags;
// there is no clearing pass.
// Depends on mdh_pkg and motion_direction_histogram_defines.svh.
`include "motion_direction_histogram_defines.svh"

module motion_direction_histogram (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  mdh_pkg::in_item_t  in_data,
    output logic               out_valid,
    input  logic               out_ready,
    output mdh_pkg::out_item_t out_data
);
    import mdh_pkg::*;

    // ------------------------------------------------------------------
    // Tangent search pipeline: stage 0 holds |dx|, |dy| and signs, stage k
    // holds the search result after testing bit (SEARCH_STEPS-k) of the
    // degree. TAN_Q16 is monotone, so the largest passing degree is found
    // by a 7-step binary search, one table read and multiply per stage.
    // ------------------------------------------------------------------
    srch_t                   s_reg  [0:SEARCH_STEPS];
    srch_t                   s_next [0:SEARCH_STEPS];
    logic [SEARCH_STEPS:0]   s_vld_reg;
    logic [SEARCH_STEPS:0]   s_adv;
    logic [SEARCH_STEPS:0]   s_ld;

    // finalize stage
    ang_item_t               f_reg;
    ang_item_t               f_next;
    logic                    f_vld_reg;
    logic                    f_ready;

    // count read-modify-write stage
    ang_item_t               m_reg;
    logic                    m_vld_reg;
    logic                    m_take;
    logic                    m_exit;
    logic [CNT_W-1:0]        m_cnt_cur;
    logic [CNT_W-1:0]        m_cnt_next;
    logic                    fwd_hit_reg;
    logic                    fwd_hit_next;
    logic [CNT_W-1:0]        fwd_val_reg;

    // count store
    logic [CNT_W-1:0]        cnt_mem [0:NUM_BINS-1];
    logic [NUM_BINS-1:0]     cnt_vld_reg;
    logic [CNT_W-1:0]        rd_data_reg;
    logic                    rd_vld_reg;
    logic [BIN_W-1:0]        rd_addr;
    logic                    mem_re;

    // frame-end dump
    logic                    dump_active_reg;
    logic [BIN_W-1:0]        dump_idx_reg;
    logic                    dump_rd;
    logic                    d_vld_reg;
    logic [BIN_W-1:0]        d_idx_reg;
    logic                    d_take;

    // output register
    logic                    out_valid_reg;
    out_item_t               out_reg;
    out_item_t               out_next;
    logic                    o_free;
    logic                    o_load;

    // ------------------------------------------------------------------
    // Stage 0: differences and signs
    // ------------------------------------------------------------------
    always_comb
    begin
        s_next[0]       = '0;
        s_next[0].xneg  = in_data.cur_x < in_data.prev_x;
        s_next[0].yneg  = in_data.cur_y < in_data.prev_y;
        s_next[0].adx   = s_next[0].xneg ? (in_data.prev_x - in_data.cur_x)
                                         : (in_data.cur_x - in_data.prev_x);
        s_next[0].ady   = s_next[0].yneg ? (in_data.prev_y - in_data.cur_y)
                                         : (in_data.cur_y - in_data.prev_y);
        s_next[0].xzero = in_data.cur_x == in_data.prev_x;
        s_next[0].ygt   = in_data.cur_y > in_data.prev_y;
        s_next[0].eof   = in_data.end_of_frame;
        s_next[0].lo    = '0;
    end

    // Search steps: test lo|step against tan(d) * |dx| <= |dy| << 16
    for (genvar k = 1; k <= SEARCH_STEPS; k++)
    begin : g_step
        localparam logic [DEG_W-1:0] STEP = DEG_W'(1 << (SEARCH_STEPS - k));
        logic [DEG_W-1:0]  cand;
        logic [PROD_W-1:0] prod;
        logic [PROD_W-1:0] lim;
        logic              hit;

        assign cand = s_reg[k-1].lo | STEP;
        assign prod = PROD_W'(tan_q16(cand)) * PROD_W'(s_reg[k-1].adx);
        assign lim  = PROD_W'({s_reg[k-1].ady, {TAN_FRAC{1'b0}}});
        assign hit  = (cand <= MAX_DEG) && (prod <= lim);

        always_comb
        begin
            s_next[k] = s_reg[k-1];
            if (hit)
            begin
                s_next[k].lo = cand;
            end
        end
    end

    // Stage handshake: a stage moves on when the next one is empty or moving
    always_comb
    begin
        s_adv[SEARCH_STEPS] = s_vld_reg[SEARCH_STEPS] && f_ready;
        for (int k = SEARCH_STEPS - 1; k >= 0; k--)
        begin
            s_adv[k] = s_vld_reg[k] && (!s_vld_reg[k+1] || s_adv[k+1]);
        end
    end

    assign in_ready = !s_vld_reg[0] || s_adv[0];

    always_comb
    begin
        s_ld[0] = in_valid && in_ready;
        for (int k = 1; k <= SEARCH_STEPS; k++)
        begin
            s_ld[k] = s_adv[k-1];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_vld_reg <= '0;
        end
        else
        begin
            s_vld_reg <= (s_vld_reg & ~s_adv) | s_ld;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int k = 0; k <= SEARCH_STEPS; k++)
        begin
            if (s_ld[k])
            begin
                s_reg[k] <= s_next[k];
            end
        end
    end

    // ------------------------------------------------------------------
    // Finalize: quadrant fix-up and bin
    // ------------------------------------------------------------------
    always_comb
    begin
        srch_t            s;
        logic             neg;
        logic [ANG_W-1:0] m9;
        s   = s_reg[SEARCH_STEPS];
        m9  = ANG_W'(s.lo);
        // atan of a negative ratio; a zero angle stays zero
        neg = (s.xneg != s.yneg) && (s.ady != '0);
        if (s.xzero)
        begin
            f_next.angle = s.ygt ? ANG_90 : ANG_270;
        end
        else if (!s.xneg)
        begin
            f_next.angle = (neg && (m9 != '0)) ? (ANG_360 - m9) : m9;
        end
        else
        begin
            f_next.angle = neg ? (ANG_180 - m9) : (ANG_180 + m9);
        end
        f_next.bin = ang_to_bin(f_next.angle);
        f_next.eof = s.eof;
    end

    assign f_ready = !f_vld_reg || m_take;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            f_vld_reg <= 1'b0;
        end
        else
        begin
            f_vld_reg <= (f_vld_reg && !m_take) || s_adv[SEARCH_STEPS];
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_adv[SEARCH_STEPS])
        begin
            f_reg <= f_next;
        end
    end

    // ------------------------------------------------------------------
    // Count read-modify-write. The read is issued as the item enters M;
    // the write happens as it leaves. If the item leaving writes the bin
    // the entering item reads, the new value is forwarded.
    // ------------------------------------------------------------------
    assign o_free = !out_valid_reg || out_ready;
    assign d_take = d_vld_reg && o_free;
    assign m_exit = m_vld_reg && o_free && !d_vld_reg;

    // hold off new items while a frame end or its dump is in flight
    assign m_take = f_vld_reg && (!m_vld_reg || m_exit) && !dump_active_reg
                    && !d_vld_reg && !(m_vld_reg && m_reg.eof);

    assign dump_rd = dump_active_reg && (!d_vld_reg || d_take);

    assign mem_re  = m_take || dump_rd;
    assign rd_addr = dump_rd ? dump_idx_reg : f_reg.bin;

    assign m_cnt_cur  = fwd_hit_reg ? fwd_val_reg : (rd_vld_reg ? rd_data_reg : '0);
    assign m_cnt_next = (m_cnt_cur == COUNT_CEIL) ? m_cnt_cur : (m_cnt_cur + 10'd1);

    assign fwd_hit_next = m_exit && (m_reg.bin == f_reg.bin);

    always_ff @(posedge clk)
    begin
        if (m_exit)
        begin
            cnt_mem[m_reg.bin] <= m_cnt_next;
        end
        if (mem_re)
        begin
            rd_data_reg <= cnt_mem[rd_addr];
            rd_vld_reg  <= cnt_vld_reg[rd_addr];
        end
    end

    // valid flags: set on write, cleared as the dump reads the bin
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_vld_reg <= '0;
        end
        else
        begin
            if (m_exit)
            begin
                cnt_vld_reg[m_reg.bin] <= 1'b1;
            end
            if (dump_rd)
            begin
                cnt_vld_reg[dump_idx_reg] <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_vld_reg <= 1'b0;
        end
        else
        begin
            m_vld_reg <= (m_vld_reg && !m_exit) || m_take;
        end
    end

    always_ff @(posedge clk)
    begin
        if (m_take)
        begin
            m_reg       <= f_reg;
            fwd_hit_reg <= fwd_hit_next;
            fwd_val_reg <= m_cnt_next;
        end
    end

    // ------------------------------------------------------------------
    // Frame-end dump: read bins in order, one per cycle while D drains
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dump_active_reg <= 1'b0;
            dump_idx_reg    <= '0;
            d_vld_reg       <= 1'b0;
            d_idx_reg       <= '0;
        end
        else
        begin
            if (m_exit && m_reg.eof)
            begin
                dump_active_reg <= 1'b1;
                dump_idx_reg    <= '0;
            end
            else if (dump_rd)
            begin
                dump_idx_reg <= dump_idx_reg + 6'd1;
                if (dump_idx_reg == LAST_BIN)
                begin
                    dump_active_reg <= 1'b0;
                end
            end

            if (dump_rd)
            begin
                d_vld_reg <= 1'b1;
                d_idx_reg <= dump_idx_reg;
            end
            else if (d_take)
            begin
                d_vld_reg <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Output register; dump items take precedence, they are older
    // ------------------------------------------------------------------
    assign o_load = d_take || m_exit;

    always_comb
    begin
        out_next = '0;
        if (d_vld_reg)
        begin
            out_next.kind      = KIND_COUNT;
            out_next.angle_deg = '0;
            out_next.bin_index = d_idx_reg;
            out_next.bin_count = rd_vld_reg ? rd_data_reg : '0;
            out_next.last      = d_idx_reg == LAST_BIN;
        end
        else
        begin
            out_next.kind      = KIND_ANGLE;
            out_next.angle_deg = m_reg.angle;
            out_next.bin_index = m_reg.bin;
            out_next.bin_count = '0;
            out_next.last      = !m_reg.eof;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (o_free)
        begin
            out_valid_reg <= o_load;
        end
    end

    always_ff @(posedge clk)
    begin
        if (o_free && o_load)
        begin
            out_reg <= out_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    `MDH_ASSERT_NEVER(a_rd_port_conflict, dump_rd && m_take, "count read port double-booked")
    `MDH_ASSERT_NEVER(a_dump_overlap, dump_active_reg && m_vld_reg, "item in counter during dump")
    `MDH_ASSERT_NEXT(a_dump_start, m_exit && m_reg.eof, dump_active_reg && dump_idx_reg == '0, "dump did not start after frame end")
    `MDH_ASSERT_IMPLY(a_dump_tail, d_vld_reg && d_idx_reg == LAST_BIN, !dump_active_reg, "dump still reading after last bin")

endmodule

### tb/tb_motion_direction_histogram.sv
// Testbench for motion_direction_histogram: streams tracked points through the block and
// checks every angle report and frame-end bin dump against a predictor kept in this file.
// Depends on mdh_pkg and the motion_direction_histogram RTL only.
module tb_motion_direction_histogram;
    import mdh_pkg::*;

    // Handshake pressure schedule. The first stage stalls the sink hard,
    // the second starves the source, the last runs both at full rate.
    typedef enum int unsigned {
        STAGE_SLOW_SINK,
        STAGE_SLOW_SOURCE,
        STAGE_FULL_RATE
    } stage_t;

    // One pending input item, tagged with the stage it belongs to
    typedef struct {
        in_item_t pt;
        stage_t   stage;
    } queued_point_t;

    localparam int unsigned QUIET_LIMIT  = 1000;  // cycles with no handshake at all
    localparam int unsigned DRAIN_CYCLES = 40;    // settle time after the last result
    localparam int unsigned RANDOM_ITEMS = 100;   // per stage
    localparam int unsigned FILL_ITEMS   = 4;     // rightward points in the closing frame

    logic      clk       = 1'b0;
    logic      rst_n     = 1'b0;
    logic      in_valid  = 1'b0;
    logic      in_ready;
    in_item_t  in_data   = '0;
    logic      out_valid;
    logic      out_ready = 1'b0;
    out_item_t out_data;

    queued_point_t    pending_points[$];
    out_item_t        expected_results[$];
    logic [CNT_W-1:0] bin_tally [NUM_BINS];

    // tan(d deg) in unsigned Q16, rounded to nearest, d = 0..89
    int unsigned tan_deg_q16 [90] = '{
        0, 1144, 2289, 3435, 4583, 5734, 6888, 8047, 9210, 10380,
        11556, 12739, 13930, 15130, 16340, 17560, 18792, 20036, 21294, 22566,
        23853, 25157, 26478, 27818, 29179, 30560, 31964, 33392, 34846, 36327,
        37837, 39378, 40951, 42560, 44205, 45889, 47615, 49385, 51202, 53070,
        54991, 56970, 59009, 61113, 63287, 65536, 67865, 70279, 72785, 75391,
        78103, 80930, 83882, 86969, 90203, 93595, 97161, 100917, 104880, 109070,
        113512, 118230, 123255, 128622, 134369, 140542, 147196, 154393, 162207, 170727,
        180059, 190330, 201699, 214359, 228551, 244584, 262851, 283868, 308323, 337153,
        371673, 413778, 466313, 533748, 623533, 749080, 937208, 1250501, 1876706, 3754555
    };

    int unsigned err_count    = 0;
    int unsigned quiet_cycles = 0;
    stage_t      drive_stage  = STAGE_SLOW_SINK;
    logic        in_fire      = 1'b0;  // input item taken at the last rising edge

    motion_direction_histogram dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    initial
    begin
        forever #6 clk = ~clk;
    end

    // Percent of cycles a side holds off, per stage
    function automatic int unsigned idle_pct(input stage_t st, input bit sender);
        case (st)
            STAGE_SLOW_SINK:   return sender ? 9 : 56;
            STAGE_SLOW_SOURCE: return sender ? 56 : 9;
            default:           return 0;
        endcase
    endfunction

    // Direction of a step in whole degrees, 0..359.
    // A step with no x movement is straight up (90) or down (270); a step of
    // zero length counts as down. Otherwise the angle is the largest table
    // degree whose tangent does not exceed |dy|/|dx|, folded into the
    // quadrant from the signs of dx and dy.
    function automatic logic [ANG_W-1:0] motion_angle(input in_item_t pt);
        logic [63:0] adx;
        logic [63:0] ady;
        logic        xneg;
        logic        yneg;
        int          m;
        int          deg;
        if (pt.cur_x == pt.prev_x)
            return (pt.cur_y > pt.prev_y) ? ANG_W'(90) : ANG_W'(270);
        xneg = pt.cur_x < pt.prev_x;
        yneg = pt.cur_y < pt.prev_y;
        adx  = xneg ? 64'(pt.prev_x - pt.cur_x) : 64'(pt.cur_x - pt.prev_x);
        ady  = yneg ? 64'(pt.prev_y - pt.cur_y) : 64'(pt.cur_y - pt.prev_y);
        m = 0;
        for (int d = 0; d < 90; d++)
            if (64'(tan_deg_q16[d]) * adx <= (ady << 16))
                m = d;
        // opposite signs give a negative angle, but only with real y motion
        deg = (xneg != yneg && ady != 0) ? -m : m;
        if (xneg)
            deg += 180;
        if (deg < 0)
            deg += 360;
        return ANG_W'(deg);
    endfunction

    // Update the bin store for one accepted point and queue what it causes:
    // the angle report, then on frame end the full dump (counts include this
    // point), after which the store starts empty.
    task automatic predict_point(input in_item_t pt);
        logic [ANG_W-1:0] ang;
        int unsigned      bin;
        out_item_t        r;
        ang = motion_angle(pt);
        bin = int'(ang) * NUM_BINS / 360;
        if (bin >= NUM_BINS)
            bin = NUM_BINS - 1;
        if (bin_tally[bin] < COUNT_CEIL)
            bin_tally[bin] = bin_tally[bin] + 1'b1;
        r           = '0;
        r.kind      = KIND_ANGLE;
        r.angle_deg = ang;
        r.bin_index = BIN_W'(bin);
        r.last      = !pt.end_of_frame;
        expected_results = {expected_results, r};
        if (pt.end_of_frame)
        begin
            for (int i = 0; i < NUM_BINS; i++)
            begin
                r           = '0;
                r.kind      = KIND_COUNT;
                r.bin_index = BIN_W'(i);
                r.bin_count = bin_tally[i];
                r.last      = (i == NUM_BINS - 1);
                expected_results = {expected_results, r};
                bin_tally[i] = '0;
            end
        end
    endtask

    task automatic check_field(input string name, input int unsigned exp_v,
                               input int unsigned act_v);
        if (exp_v != act_v)
        begin
            $error("%s: expected %0d, got %0d", name, exp_v, act_v);
            err_count++;
        end
    endtask

    task automatic add_point(input int unsigned px, input int unsigned py,
                             input int unsigned cx, input int unsigned cy,
                             input bit eof, input stage_t st);
        queued_point_t q;
        q.pt.prev_x       = COORD_BITS'(px);
        q.pt.prev_y       = COORD_BITS'(py);
        q.pt.cur_x        = COORD_BITS'(cx);
        q.pt.cur_y        = COORD_BITS'(cy);
        q.pt.end_of_frame = eof;
        q.stage           = st;
        pending_points = {pending_points, q};
    endtask

    // Random point: half short tracker-like steps, plus full-range jumps,
    // pure vertical and horizontal steps, and corner coordinates.
    task automatic add_random_point(input stage_t st);
        int unsigned px;
        int unsigned py;
        int unsigned cx;
        int unsigned cy;
        int unsigned pick;
        pick = $urandom_range(9);
        px   = $urandom_range(65535);
        py   = $urandom_range(65535);
        if (pick < 5)
        begin
            cx = px + $urandom_range(80) - 40;
            cy = py + $urandom_range(80) - 40;
        end
        else if (pick < 7)
        begin
            cx = $urandom_range(65535);
            cy = $urandom_range(65535);
        end
        else if (pick == 7)
        begin
            cx = px;
            cy = (($urandom_range(3) == 0) ? py : $urandom_range(65535));
        end
        else if (pick == 8)
        begin
            cx = $urandom_range(65535);
            cy = py;
        end
        else
        begin
            px = $urandom_range(1) ? 65535 : 0;
            py = $urandom_range(1) ? 65535 : 0;
            cx = $urandom_range(1) ? 65535 : 0;
            cy = $urandom_range(1) ? 65535 : 0;
        end
        add_point(px, py, cx, cy, ($urandom_range(19) == 0), st);
    endtask

    // Driver: a new item goes out only once the previous one was taken, so
    // valid and payload hold steady while the block stalls.
    always @(negedge clk)
    begin
        queued_point_t q;
        if (rst_n)
        begin
            if (in_fire || !in_valid)
            begin
                if (pending_points.size() != 0 &&
                    $urandom_range(99) >= idle_pct(pending_points[0].stage, 1'b1))
                begin
                    q           = pending_points.pop_front();
                    drive_stage = q.stage;
                    in_data  <= q.pt;
                    in_valid <= 1'b1;
                end
                else
                    in_valid <= 1'b0;
            end
            out_ready <= ($urandom_range(99) >= idle_pct(drive_stage, 1'b0));
        end
    end

    // Monitor: predicts on every accepted input item, checks every accepted
    // result against the oldest expectation, and watches for a hang.
    always @(posedge clk)
    begin
        out_item_t exp_r;
        if (rst_n)
        begin
            in_fire <= in_valid && in_ready;
            if (in_valid && in_ready)
                predict_point(in_data);
            if (out_valid && out_ready)
            begin
                if (expected_results.size() == 0)
                begin
                    $error("result with nothing expected: kind %0d angle %0d bin %0d count %0d",
                           out_data.kind, out_data.angle_deg, out_data.bin_index,
                           out_data.bin_count);
                    err_count++;
                end
                else
                begin
                    exp_r = expected_results.pop_front();
                    check_field("kind", exp_r.kind, out_data.kind);
                    check_field("angle_deg", exp_r.angle_deg, out_data.angle_deg);
                    check_field("bin_index", exp_r.bin_index, out_data.bin_index);
                    check_field("bin_count", exp_r.bin_count, out_data.bin_count);
                    check_field("last", exp_r.last, out_data.last);
                end
            end
            if ((in_valid && in_ready) || (out_valid && out_ready))
                quiet_cycles <= 0;
            else if (quiet_cycles + 1 >= QUIET_LIMIT)
            begin
                $display("tb_motion_direction_histogram: done, errors");
                $finish;
            end
            else
                quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial
    begin
        int unsigned px;
        int unsigned py;
        for (int i = 0; i < NUM_BINS; i++)
            bin_tally[i] = '0;

        // Directed points: axis directions, zero-length steps, each quadrant,
        // steepest and shallowest slopes, the just-below-zero wrap to 359,
        // coordinate extremes, and frame ends back to back.
        add_point(0, 0, 0, 0, 1'b0, STAGE_SLOW_SINK);                 // zero step
        add_point(65535, 65535, 65535, 65535, 1'b0, STAGE_SLOW_SINK); // zero step, max
        add_point(100, 100, 100, 65535, 1'b0, STAGE_SLOW_SINK);       // straight up
        add_point(65535, 65535, 65535, 0, 1'b0, STAGE_SLOW_SINK);     // straight down
        add_point(0, 0, 65535, 0, 1'b0, STAGE_SLOW_SINK);             // right, 0
        add_point(65535, 5, 0, 5, 1'b0, STAGE_SLOW_SINK);             // left, 180
        add_point(0, 0, 1000, 1000, 1'b0, STAGE_SLOW_SINK);           // 45
        add_point(1000, 0, 0, 1000, 1'b0, STAGE_SLOW_SINK);           // 135
        add_point(1000, 1000, 0, 0, 1'b0, STAGE_SLOW_SINK);           // 225
        add_point(0, 1000, 1000, 0, 1'b0, STAGE_SLOW_SINK);           // 315
        add_point(0, 0, 1, 65535, 1'b0, STAGE_SLOW_SINK);             // steepest, 89
        add_point(65535, 0, 65534, 65535, 1'b0, STAGE_SLOW_SINK);     // steep left
        add_point(0, 0, 65535, 1, 1'b0, STAGE_SLOW_SINK);             // shallow up
        add_point(0, 1, 65535, 0, 1'b0, STAGE_SLOW_SINK);             // shallow down, -0
        add_point(65535, 0, 0, 1, 1'b0, STAGE_SLOW_SINK);             // shallow, left
        add_point(65535, 1, 0, 0, 1'b0, STAGE_SLOW_SINK);             // shallow, left down
        add_point(0, 20, 1000, 0, 1'b0, STAGE_SLOW_SINK);             // 359
        add_point(65535, 0, 0, 65535, 1'b0, STAGE_SLOW_SINK);         // corner to corner
        add_point(0, 65535, 65535, 0, 1'b1, STAGE_SLOW_SINK);         // frame end
        add_point(7, 7, 7, 8, 1'b1, STAGE_SLOW_SINK);                 // lone point frame
        add_point(9, 9, 3, 9, 1'b1, STAGE_SLOW_SINK);                 // and another

        // Random frames under each pressure stage
        repeat (RANDOM_ITEMS) add_random_point(STAGE_SLOW_SINK);
        repeat (RANDOM_ITEMS) add_random_point(STAGE_SLOW_SOURCE);
        repeat (RANDOM_ITEMS) add_random_point(STAGE_FULL_RATE);

        // Closing frames: several points in bin 0 and a few in the top bin,
        // then a short frame shows the store cleared.
        add_point(0, 0, 0, 0, 1'b1, STAGE_FULL_RATE);
        repeat (FILL_ITEMS)
        begin
            px = $urandom_range(60000);
            py = $urandom_range(65535);
            add_point(px, py, px + $urandom_range(1, 5000), py, 1'b0, STAGE_FULL_RATE);
        end
        repeat (3) add_point(0, 20, 1000, 0, 1'b0, STAGE_FULL_RATE);
        add_point(5, 5, 6, 5, 1'b1, STAGE_FULL_RATE);
        add_point(1000, 1000, 0, 0, 1'b0, STAGE_FULL_RATE);
        add_point(1000, 1000, 0, 0, 1'b1, STAGE_FULL_RATE);

        // Reset: held low from the start, released away from the rising edge
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        while (pending_points.size() != 0 || in_valid || expected_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (err_count == 0 && expected_results.size() == 0)
            $display("tb_motion_direction_histogram: done, clean");
        else
            $display("tb_motion_direction_histogram: done, errors");
        $finish;
    end

endmodule
